>>> design/gpg_pkg.sv
// Shared constants and types for the hashed Gaussian pair generator.
// No dependencies; every design file imports this package.
package gpg_pkg;

    // Widths of the internal number formats
    localparam int MANT_W   = 25;   // odd uniform numerator, u = m / 2^25
    localparam int RAD_W    = 31;   // radius, Q.28
    localparam int TRIG_W   = 33;   // sine / cosine, Q.32 (cosine may reach 1.0)
    localparam int LSQ_W    = 38;   // -2 ln u1, Q.32
    localparam int OUT_W    = 16;

    typedef logic [MANT_W-1:0] t_mant;
    typedef logic [RAD_W-1:0]  t_radius;
    typedef logic [TRIG_W-1:0] t_trig;
    typedef logic [LSQ_W-1:0]  t_lsq;
    typedef logic [2:0]        t_oct;

    // Integer hash constants
    localparam logic [31:0] HASH_SEED_XOR = 32'd61;
    localparam logic [31:0] WANG_MUL      = 32'h27d4eb2d;
    localparam logic [31:0] GOLDEN_XOR    = 32'h9e3779b9;

    // Log / radius constants
    localparam logic [34:0] LOG_T_BASE  = 35'(25) << 30;     // 25.0 in Q.30
    localparam logic [28:0] TWO_LN2_Q28 = 29'd372130559;

    // Angle constants
    localparam logic [31:0] QPI_Q32 = 32'd3373259426;        // pi/4 in Q.32
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    // Taylor series: per-term divisors and their truncated reciprocals (2^32 / d)
    localparam int SERIES_TERMS = 8;
    localparam logic [8:0] SIN_DEN [SERIES_TERMS] =
        '{9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272};
    localparam logic [8:0] COS_DEN [SERIES_TERMS] =
        '{9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240};
    localparam logic [31:0] SIN_RCP [SERIES_TERMS] = '{
        32'(ONE_Q32 / 33'd6),   32'(ONE_Q32 / 33'd20),  32'(ONE_Q32 / 33'd42),
        32'(ONE_Q32 / 33'd72),  32'(ONE_Q32 / 33'd110), 32'(ONE_Q32 / 33'd156),
        32'(ONE_Q32 / 33'd210), 32'(ONE_Q32 / 33'd272)};
    localparam logic [31:0] COS_RCP [SERIES_TERMS] = '{
        32'(ONE_Q32 / 33'd2),   32'(ONE_Q32 / 33'd12),  32'(ONE_Q32 / 33'd30),
        32'(ONE_Q32 / 33'd56),  32'(ONE_Q32 / 33'd90),  32'(ONE_Q32 / 33'd132),
        32'(ONE_Q32 / 33'd182), 32'(ONE_Q32 / 33'd240)};

    // Output saturation
    localparam logic [OUT_W-1:0] OUT_MAX = 16'd32767;

    // Pipeline depths of the units
    localparam int HASH_STAGES = 3;
    localparam int LOG_FRAC    = 30;
    localparam int LOG_STAGES  = LOG_FRAC + 5;
    localparam int SQRT_STAGES = 31;
    localparam int TRIG_STAGES = 3 + 3 * SERIES_TERMS + 1;

endpackage

>>> design/gpg_hash.sv
// Dual integer hash of the draw index, producing the two odd uniform numerators.
// Depends on gpg_pkg.
module gpg_hash (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [31:0]   i_index,
    output logic          o_valid,
    output gpg_pkg::t_mant o_m1,
    output gpg_pkg::t_mant o_m2
);
    import gpg_pkg::*;

    logic [HASH_STAGES-1:0] r_v;
    logic [31:0] r_a1, r_a2, r_p1, r_p2;
    t_mant       r_m1, r_m2;
    logic [31:0] n_a1, n_a2, n_p1, n_p2, h1, h2;

    // xor-shift, times 9, xor-shift: everything before the wide multiply
    function automatic logic [31:0] f_mix_pre(input logic [31:0] v);
        logic [31:0] a;
        logic [31:0] b;
        a = (v ^ HASH_SEED_XOR) ^ (v >> 16);
        b = a + (a << 3);
        return b ^ (b >> 4);
    endfunction

    assign n_a1 = f_mix_pre(i_index);
    assign n_a2 = f_mix_pre(i_index ^ GOLDEN_XOR);

    // low half of the 32x32 product
    assign n_p1 = r_a1 * WANG_MUL;
    assign n_p2 = r_a2 * WANG_MUL;

    assign h1 = r_p1 ^ (r_p1 >> 15);
    assign h2 = r_p2 ^ (r_p2 >> 15);

    // valid travels with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[HASH_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1 <= n_a1;
            r_a2 <= n_a2;
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            r_m1 <= {h1[31:8], 1'b1};
            r_m2 <= {h2[31:8], 1'b1};
        end
    end

    assign o_valid = r_v[HASH_STAGES-1];
    assign o_m1    = r_m1;
    assign o_m2    = r_m2;

endmodule

>>> design/gpg_log.sv
// Pipelined log2 by repeated squaring, then -2 ln(u1) in Q.32.
// Depends on gpg_pkg. Carries the second numerator alongside.
module gpg_log (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  gpg_pkg::t_mant i_m1,
    input  gpg_pkg::t_mant i_m2,
    output logic           o_valid,
    output gpg_pkg::t_lsq  o_lsq,
    output gpg_pkg::t_mant o_m2
);
    import gpg_pkg::*;

    logic [LOG_STAGES-1:0] r_v;
    t_mant       r_m2 [LOG_STAGES];

    t_mant       r_m;
    logic [4:0]  r_e0;
    logic [4:0]  n_e;
    logic [30:0] n_x;

    logic [30:0]         r_x  [LOG_FRAC+1];
    logic [LOG_FRAC-1:0] r_fr [LOG_FRAC+1];
    logic [4:0]          r_e  [LOG_FRAC+1];

    logic [34:0] r_t, n_t;
    logic [45:0] r_ph, n_ph;
    logic [46:0] r_pl, n_pl;
    logic [63:0] n_sum;
    t_lsq        r_lsq;

    // valid and side payload shift along
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[LOG_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m2[0] <= i_m2;
            for (int k = 1; k < LOG_STAGES; k++) begin
                r_m2[k] <= r_m2[k-1];
            end
        end
    end

    // leading one position
    always_comb begin
        n_e = '0;
        for (int b = 0; b < MANT_W; b++) begin
            if (i_m1[b]) begin
                n_e = 5'(b);
            end
        end
    end

    // normalize to Q1.30
    assign n_x = {6'b0, r_m} << (5'd30 - r_e0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m     <= i_m1;
            r_e0    <= n_e;
            r_x[0]  <= n_x;
            r_fr[0] <= '0;
            r_e[0]  <= r_e0;
        end
    end

    // one fraction bit per squaring stage
    for (genvar i = 0; i < LOG_FRAC; i++) begin : g_sq
        logic [61:0]         sq;
        logic [31:0]         y;
        logic [LOG_FRAC-1:0] n_fr;

        assign sq = 62'(r_x[i]) * 62'(r_x[i]);
        assign y  = sq[61:30];

        always_comb begin
            n_fr = r_fr[i];
            n_fr[LOG_FRAC-1-i] = y[31];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]  <= y[31] ? y[31:1] : y[30:0];
                r_fr[i+1] <= n_fr;
                r_e[i+1]  <= r_e[i];
            end
        end
    end

    // -log2(u1), then split product with 2 ln 2, then round
    assign n_t   = LOG_T_BASE - {r_e[LOG_FRAC], r_fr[LOG_FRAC]};
    assign n_ph  = 46'(r_t[34:18]) * 46'(TWO_LN2_Q28);
    assign n_pl  = 47'(r_t[17:0]) * 47'(TWO_LN2_Q28);
    assign n_sum = (64'(r_ph) << 18) + 64'(r_pl) + (64'(1) << 25);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t   <= n_t;
            r_ph  <= n_ph;
            r_pl  <= n_pl;
            r_lsq <= n_sum[63:26];
        end
    end

    assign o_valid = r_v[LOG_STAGES-1];
    assign o_lsq   = r_lsq;
    assign o_m2    = r_m2[LOG_STAGES-1];

endmodule

>>> design/gpg_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on gpg_pkg. Carries the second numerator alongside.
module gpg_sqrt (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  gpg_pkg::t_lsq    i_lsq,
    input  gpg_pkg::t_mant   i_m2,
    output logic             o_valid,
    output gpg_pkg::t_radius o_radius,
    output gpg_pkg::t_mant   o_m2
);
    import gpg_pkg::*;

    logic [SQRT_STAGES-1:0] r_v;
    logic [61:0] r_rem  [SQRT_STAGES];
    logic [62:0] r_root [SQRT_STAGES];
    t_mant       r_m2   [SQRT_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[SQRT_STAGES-2:0], i_valid};
        end
    end

    // radicand is lsq << 24, below 2^62; first trial bit is 2^60
    for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_bit
        localparam logic [62:0] BIT = 63'(1) << (60 - 2 * i);
        logic [61:0] a_rem;
        logic [62:0] a_root;
        t_mant       a_m2;
        logic [62:0] trial;
        logic        ge;

        if (i == 0) begin : g_first
            assign a_rem  = {i_lsq, 24'b0};
            assign a_root = '0;
            assign a_m2   = i_m2;
        end else begin : g_next
            assign a_rem  = r_rem[i-1];
            assign a_root = r_root[i-1];
            assign a_m2   = r_m2[i-1];
        end

        assign trial = a_root + BIT;
        assign ge    = {1'b0, a_rem} >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i]  <= ge ? (a_rem - trial[61:0]) : a_rem;
                r_root[i] <= ge ? ((a_root >> 1) + BIT) : (a_root >> 1);
                r_m2[i]   <= a_m2;
            end
        end
    end

    assign o_valid  = r_v[SQRT_STAGES-1];
    assign o_radius = r_root[SQRT_STAGES-1][RAD_W-1:0];
    assign o_m2     = r_m2[SQRT_STAGES-1];

endmodule

>>> design/gpg_trig.sv
// Angle reduction to an octant and pipelined Taylor sine/cosine in Q.32.
// Depends on gpg_pkg. Carries the radius alongside.
module gpg_trig (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  gpg_pkg::t_mant   i_m2,
    input  gpg_pkg::t_radius i_radius,
    output logic             o_valid,
    output gpg_pkg::t_oct    o_oct,
    output gpg_pkg::t_radius o_radius,
    output gpg_pkg::t_trig   o_cos,
    output gpg_pkg::t_trig   o_sin
);
    import gpg_pkg::*;

    logic [TRIG_STAGES-1:0] r_v;
    t_oct    r_oct [TRIG_STAGES];
    t_radius r_rad [TRIG_STAGES];

    logic [22:0] r_k, n_k;
    logic [54:0] n_kx;
    logic [31:0] r_x, r_xb, r_x2;
    logic [63:0] n_xx;

    // per-term stage registers: A = product with x^2, B = reciprocal, C = correction
    logic [31:0] ra_ps [SERIES_TERMS];
    logic [31:0] ra_pc [SERIES_TERMS];
    t_trig       ra_s  [SERIES_TERMS];
    t_trig       ra_c  [SERIES_TERMS];
    logic [31:0] ra_x2 [SERIES_TERMS];
    logic [31:0] rb_ps [SERIES_TERMS];
    logic [31:0] rb_pc [SERIES_TERMS];
    logic [31:0] rb_qs [SERIES_TERMS];
    logic [31:0] rb_qc [SERIES_TERMS];
    t_trig       rb_s  [SERIES_TERMS];
    t_trig       rb_c  [SERIES_TERMS];
    logic [31:0] rb_x2 [SERIES_TERMS];
    logic [31:0] rc_qs [SERIES_TERMS];
    logic [31:0] rc_qc [SERIES_TERMS];
    t_trig       rc_s  [SERIES_TERMS];
    t_trig       rc_c  [SERIES_TERMS];
    logic [31:0] rc_x2 [SERIES_TERMS];
    t_trig       r_fs, r_fc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[TRIG_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oct[0] <= i_m2[24:22];
            r_rad[0] <= i_radius;
            for (int k = 1; k < TRIG_STAGES; k++) begin
                r_oct[k] <= r_oct[k-1];
                r_rad[k] <= r_rad[k-1];
            end
        end
    end

    // odd octants mirror the angle inside the octant
    assign n_k  = i_m2[22] ? (23'(1) << 22) - {1'b0, i_m2[21:0]} : {1'b0, i_m2[21:0]};
    assign n_kx = 55'(r_k) * 55'(QPI_Q32) + (55'(1) << 21);
    assign n_xx = 64'(r_x) * 64'(r_x);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k  <= n_k;
            r_x  <= n_kx[53:22];
            r_xb <= r_x;
            r_x2 <= n_xx[63:32];
        end
    end

    for (genvar j = 0; j < SERIES_TERMS; j++) begin : g_term
        logic [31:0] a_ms;
        logic [31:0] a_x2;
        t_trig       a_s;
        t_trig       a_c;
        logic [31:0] a_pc;
        logic [63:0] prod_s;
        logic [63:0] rcp_s;
        logic [63:0] rcp_c;
        logic [40:0] back_s;
        logic [40:0] back_c;
        logic [31:0] rem_s;
        logic [31:0] rem_c;

        // stage A: fold the previous term into the sums, multiply by x^2
        if (j == 0) begin : g_first
            assign a_ms = r_xb;
            assign a_x2 = r_x2;
            assign a_s  = {1'b0, r_xb};
            assign a_c  = ONE_Q32;
            assign a_pc = r_x2;
        end else begin : g_next
            logic [63:0] prod_c;

            assign a_ms = rc_qs[j-1];
            assign a_x2 = rc_x2[j-1];
            if (j % 2 == 1) begin : g_sub
                assign a_s = rc_s[j-1] - {1'b0, rc_qs[j-1]};
                assign a_c = rc_c[j-1] - {1'b0, rc_qc[j-1]};
            end else begin : g_add
                assign a_s = rc_s[j-1] + {1'b0, rc_qs[j-1]};
                assign a_c = rc_c[j-1] + {1'b0, rc_qc[j-1]};
            end
            assign prod_c = 64'(rc_qc[j-1]) * 64'(a_x2);
            assign a_pc   = prod_c[63:32];
        end

        assign prod_s = 64'(a_ms) * 64'(a_x2);

        // stage B: quotient estimate by reciprocal, at most one low
        assign rcp_s = 64'(ra_ps[j]) * 64'(SIN_RCP[j]);
        assign rcp_c = 64'(ra_pc[j]) * 64'(COS_RCP[j]);

        // stage C: remainder check bumps the estimate
        assign back_s = 41'(rb_qs[j]) * 41'(SIN_DEN[j]);
        assign back_c = 41'(rb_qc[j]) * 41'(COS_DEN[j]);
        assign rem_s  = rb_ps[j] - back_s[31:0];
        assign rem_c  = rb_pc[j] - back_c[31:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                ra_ps[j] <= prod_s[63:32];
                ra_pc[j] <= a_pc;
                ra_s[j]  <= a_s;
                ra_c[j]  <= a_c;
                ra_x2[j] <= a_x2;

                rb_ps[j] <= ra_ps[j];
                rb_pc[j] <= ra_pc[j];
                rb_qs[j] <= rcp_s[63:32];
                rb_qc[j] <= rcp_c[63:32];
                rb_s[j]  <= ra_s[j];
                rb_c[j]  <= ra_c[j];
                rb_x2[j] <= ra_x2[j];

                rc_qs[j] <= rb_qs[j] + 32'(rem_s >= 32'(SIN_DEN[j]));
                rc_qc[j] <= rb_qc[j] + 32'(rem_c >= 32'(COS_DEN[j]));
                rc_s[j]  <= rb_s[j];
                rc_c[j]  <= rb_c[j];
                rc_x2[j] <= rb_x2[j];
            end
        end
    end

    // last term is added
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fs <= rc_s[SERIES_TERMS-1] + {1'b0, rc_qs[SERIES_TERMS-1]};
            r_fc <= rc_c[SERIES_TERMS-1] + {1'b0, rc_qc[SERIES_TERMS-1]};
        end
    end

    assign o_valid  = r_v[TRIG_STAGES-1];
    assign o_oct    = r_oct[TRIG_STAGES-1];
    assign o_radius = r_rad[TRIG_STAGES-1];
    assign o_cos    = r_fc;
    assign o_sin    = r_fs;

endmodule

>>> design/hashed_gaussian_pair_generator_top.sv
// Hashed Gaussian pair generator: index -> hash -> log -> sqrt -> sin/cos -> Q4.12 pair.
// Throughput: one pair per cycle while the skid register is empty; the whole pipeline advances on one enable.
// A stalled output parks one beat in a skid register; input ready drops only then.
// Reset clears all valid bits and the output/skid flags; the data registers are not reset.
// Depends on gpg_pkg, gpg_hash, gpg_log, gpg_sqrt, gpg_trig.
module hashed_gaussian_pair_generator_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_draw_index,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_normal_cos,
    output logic signed [15:0] o_normal_sin
);
    import gpg_pkg::*;

    logic    en;
    logic    h_v, l_v, s_v, t_v;
    t_mant   h_m1, h_m2, l_m2, s_m2;
    t_lsq    l_lsq;
    t_radius s_rad, t_rad;
    t_oct    t_octant;
    t_trig   t_cos, t_sin;

    gpg_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_index (i_draw_index),
        .o_valid (h_v),
        .o_m1    (h_m1),
        .o_m2    (h_m2)
    );

    gpg_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (h_v),
        .i_m1    (h_m1),
        .i_m2    (h_m2),
        .o_valid (l_v),
        .o_lsq   (l_lsq),
        .o_m2    (l_m2)
    );

    gpg_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (l_v),
        .i_lsq    (l_lsq),
        .i_m2     (l_m2),
        .o_valid  (s_v),
        .o_radius (s_rad),
        .o_m2     (s_m2)
    );

    gpg_trig u_trig (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (s_v),
        .i_m2     (s_m2),
        .i_radius (s_rad),
        .o_valid  (t_v),
        .o_oct    (t_octant),
        .o_radius (t_rad),
        .o_cos    (t_cos),
        .o_sin    (t_sin)
    );

    // ---- octant mapping and split products ----
    logic        swap, cneg, sneg;
    t_trig       cv, sv;
    logic [47:0] n_chi, n_shi;
    logic [46:0] n_clo, n_slo;
    logic [47:0] r_chi, r_shi;
    logic [46:0] r_clo, r_slo;
    logic        r_cneg, r_sneg;
    logic [1:0]  r_ev;

    assign swap = t_octant[1] ^ t_octant[0];
    assign cneg = t_octant[2] ^ t_octant[1];
    assign sneg = t_octant[2];
    assign cv   = swap ? t_sin : t_cos;
    assign sv   = swap ? t_cos : t_sin;

    assign n_chi = 48'(t_rad) * 48'(cv[32:16]);
    assign n_clo = 47'(t_rad) * 47'(cv[15:0]);
    assign n_shi = 48'(t_rad) * 48'(sv[32:16]);
    assign n_slo = 47'(t_rad) * 47'(sv[15:0]);

    // ---- round, saturate, sign ----
    logic [63:0] sum_c, sum_s;
    logic [15:0] mag_c, mag_s, sat_c, sat_s;
    logic [15:0] r_pc, r_ps;

    assign sum_c = (64'(r_chi) << 16) + 64'(r_clo) + (64'(1) << 47);
    assign sum_s = (64'(r_shi) << 16) + 64'(r_slo) + (64'(1) << 47);
    assign mag_c = sum_c[63:48];
    assign mag_s = sum_s[63:48];
    assign sat_c = (mag_c > OUT_MAX) ? OUT_MAX : mag_c;
    assign sat_s = (mag_s > OUT_MAX) ? OUT_MAX : mag_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= '0;
        end else if (en) begin
            r_ev <= {r_ev[0], t_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_chi  <= n_chi;
            r_clo  <= n_clo;
            r_shi  <= n_shi;
            r_slo  <= n_slo;
            r_cneg <= cneg;
            r_sneg <= sneg;
            r_pc   <= r_cneg ? (16'd0 - sat_c) : sat_c;
            r_ps   <= r_sneg ? (16'd0 - sat_s) : sat_s;
        end
    end

    // ---- output register with skid beat ----
    logic        r_o_valid, r_skid_v;
    logic [15:0] r_o_cos, r_o_sin, r_sk_cos, r_sk_sin;
    logic        out_free, pv;

    assign pv       = r_ev[1];
    assign out_free = !r_o_valid || i_ready;
    assign en       = !r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_skid_v  <= 1'b0;
        end else if (r_skid_v) begin
            if (out_free) begin
                r_o_valid <= 1'b1;
                r_skid_v  <= 1'b0;
            end
        end else if (pv) begin
            if (out_free) begin
                r_o_valid <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (out_free) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (out_free) begin
                r_o_cos <= r_sk_cos;
                r_o_sin <= r_sk_sin;
            end
        end else if (pv) begin
            if (out_free) begin
                r_o_cos <= r_pc;
                r_o_sin <= r_ps;
            end else begin
                r_sk_cos <= r_pc;
                r_sk_sin <= r_ps;
            end
        end
    end

    assign o_ready      = en;
    assign o_valid      = r_o_valid;
    assign o_normal_cos = r_o_cos;
    assign o_normal_sin = r_o_sin;

endmodule
